// ===== sv/rgb_image_rms_difference_core_macros.svh =====
// Assertion macros shared by the RMS difference core modules.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef RGB_IMAGE_RMS_DIFFERENCE_CORE_MACROS_SVH
`define RGB_IMAGE_RMS_DIFFERENCE_CORE_MACROS_SVH

// Property holds at every clock edge outside reset.
`define RMSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rmsd_pkg.sv =====
// Types and constants of the RGB RMS difference core.
// Used by rmsd_ctrl, rmsd_dp and the top level; depends on nothing.
`default_nettype none

package rmsd_pkg;

  localparam int DIM_W      = 13;
  localparam int CH_W       = 8;
  localparam int ADD_W      = 18;  // three squared 8-bit differences
  localparam int SUM_W      = 42;
  localparam int WH_W       = 2 * DIM_W;
  localparam int DEN_W      = 44;  // 3 * 255^2 * w * h
  localparam int Q_W        = 32;
  localparam int ROOT_W     = 16;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int RMS_W      = 17;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;

  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [DEN_W-1:0] SCALE   = DEN_W'(195075);  // 3 * 255 * 255
  localparam logic [RMS_W-1:0] ONE_Q16 = RMS_W'(65536);

  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_WIDTH   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_HEIGHT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SECOND_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_SCALE,
    ST_CHECK,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;       // input beat accepted
    logic ld_wh;      // load overlap area
    logic ld_den;     // load scaled denominator
    logic check;      // decide saturation, start division, clear sum
    logic div_step;   // one quotient bit
    logic sqrt_step;  // one root bit
    logic ld_out;     // load output register
  } cmd_t;

  typedef struct packed {
    logic sat;        // result is 1.0 without division
    logic out_free;   // output register can take a result
  } status_t;

endpackage

`default_nettype wire

// ===== sv/rmsd_ctrl.sv =====
// Controller of the RMS difference core: input gating and the final
// divide and square-root sequence. Depends on rmsd_pkg and the macro header.
`default_nettype none
`include "rgb_image_rms_difference_core_macros.svh"

module rmsd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_tlast,
  output logic                 in_tready,
  input  rmsd_pkg::status_t    status,
  output rmsd_pkg::cmd_t       cmd
);

  rmsd_pkg::state_t               state_r, state_nxt;
  logic [rmsd_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsd_pkg::ST_ACCUM;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      rmsd_pkg::ST_ACCUM: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = rmsd_pkg::ST_FLUSH;
        end
      end
      rmsd_pkg::ST_FLUSH: begin
        // last beat drains into the sum this cycle
        cmd.ld_wh = 1'b1;
        state_nxt = rmsd_pkg::ST_SCALE;
      end
      rmsd_pkg::ST_SCALE: begin
        cmd.ld_den = 1'b1;
        state_nxt  = rmsd_pkg::ST_CHECK;
      end
      rmsd_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        state_nxt = status.sat ? rmsd_pkg::ST_DONE : rmsd_pkg::ST_DIV;
      end
      rmsd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == rmsd_pkg::CNT_W'(rmsd_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rmsd_pkg::ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rmsd_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == rmsd_pkg::CNT_W'(rmsd_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rmsd_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rmsd_pkg::ST_DONE: begin
        // hold until the output register frees up
        if (status.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = rmsd_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_nxt = rmsd_pkg::ST_ACCUM;
      end
    endcase
  end

  `RMSD_ASSERT_NEXT(a_last_stalls_input, in_tvalid && in_tready && in_tlast, !in_tready, "input taken after last beat")
  `RMSD_ASSERT(a_sqrt_cnt_bound, (state_r == rmsd_pkg::ST_SQRT) |-> (cnt_r < rmsd_pkg::CNT_W'(rmsd_pkg::SQRT_STEPS)), "root step count overrun")
  `RMSD_ASSERT(a_one_cmd, $onehot0({cmd.ld_wh, cmd.ld_den, cmd.check, cmd.div_step, cmd.sqrt_step, cmd.ld_out, cmd.take}), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== sv/rmsd_dp.sv =====
// Datapath of the RMS difference core: configuration registers, squared
// difference accumulator, restoring divider, bit-serial square root, output
// register. Depends on rmsd_pkg and the macro header.
`default_nettype none
`include "rgb_image_rms_difference_core_macros.svh"

module rmsd_dp #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire  [rmsd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [rmsd_pkg::DIM_W-1:0]            cfg_wr_data,
  input  wire  [rmsd_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [rmsd_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  rmsd_pkg::cmd_t                        cmd,
  output rmsd_pkg::status_t                     status
);

  localparam int DW = rmsd_pkg::DIM_W;

  logic [DW-1:0] fw_r, fh_r, sw_r, sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= DW'(1);
      fh_r <= DW'(1);
      sw_r <= DW'(1);
      sh_r <= DW'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rmsd_pkg::REG_FIRST_WIDTH:   fw_r <= cfg_wr_data;
        rmsd_pkg::REG_FIRST_HEIGHT:  fh_r <= cfg_wr_data;
        rmsd_pkg::REG_SECOND_WIDTH:  sw_r <= cfg_wr_data;
        rmsd_pkg::REG_SECOND_HEIGHT: sh_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Squared channel differences, one stage ahead of the accumulator
  function automatic logic [2*rmsd_pkg::CH_W-1:0] sq_diff(
    input logic [rmsd_pkg::CH_W-1:0] a,
    input logic [rmsd_pkg::CH_W-1:0] b
  );
    logic [rmsd_pkg::CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  logic                          s1_valid_r;
  logic [rmsd_pkg::ADD_W-1:0]    s1_add_r, s1_add_nxt;

  assign s1_add_nxt = rmsd_pkg::ADD_W'(sq_diff(in_tdata[7:0],   in_tdata[31:24]))
                    + rmsd_pkg::ADD_W'(sq_diff(in_tdata[15:8],  in_tdata[39:32]))
                    + rmsd_pkg::ADD_W'(sq_diff(in_tdata[23:16], in_tdata[47:40]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s1_add_r <= s1_add_nxt;
    end
  end

  // Saturating sum of squared differences
  logic [rmsd_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [rmsd_pkg::SUM_W:0]   sum_wide;

  assign sum_wide = {1'b0, sum_r} + (rmsd_pkg::SUM_W + 1)'(s1_add_r);

  always_comb begin
    sum_nxt = sum_r;
    priority if (cmd.check) begin
      sum_nxt = '0;
    end else if (s1_valid_r) begin
      sum_nxt = sum_wide[rmsd_pkg::SUM_W] ? '1 : sum_wide[rmsd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // Overlap size, clamped, and the scaled denominator 3 * 255^2 * w * h
  logic [DW-1:0]                 w_min, h_min, w_cl, h_cl;
  logic [rmsd_pkg::WH_W-1:0]     wh_r;
  logic [rmsd_pkg::DEN_W-1:0]    den_r;

  assign w_min = (fw_r < sw_r) ? fw_r : sw_r;
  assign h_min = (fh_r < sh_r) ? fh_r : sh_r;
  assign w_cl  = (32'(w_min) > MAX_WIDTH)  ? DW'(MAX_WIDTH)  : w_min;
  assign h_cl  = (32'(h_min) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : h_min;

  always_ff @(posedge clk) begin
    if (cmd.ld_wh) begin
      wh_r <= rmsd_pkg::WH_W'(w_cl) * rmsd_pkg::WH_W'(h_cl);
    end
    if (cmd.ld_den) begin
      den_r <= rmsd_pkg::DEN_W'(wh_r) * rmsd_pkg::SCALE;
    end
  end

  // Mismatch uses the raw register values
  logic [DW-1:0] dw_abs, dh_abs;
  logic          mism, den_zero, too_big, sat_now;

  assign dw_abs   = (fw_r > sw_r) ? (fw_r - sw_r) : (sw_r - fw_r);
  assign dh_abs   = (fh_r > sh_r) ? (fh_r - sh_r) : (sh_r - fh_r);
  assign mism     = (dw_abs > DW'(1)) || (dh_abs > DW'(1));
  assign den_zero = (den_r == '0);
  // sum >= den means the quotient reaches 2^32, so the root saturates
  assign too_big  = (rmsd_pkg::DEN_W'(sum_r) >= den_r);
  assign sat_now  = mism || den_zero || too_big;

  // Restoring division of sum * 2^32 by den, then root of the quotient
  logic                          sat_r, mism_r;
  logic [rmsd_pkg::DEN_W-1:0]    rem_r;
  logic [rmsd_pkg::Q_W-1:0]      q_r;
  logic [rmsd_pkg::SREM_W-1:0]   srem_r;
  logic [rmsd_pkg::ROOT_W-1:0]   root_r;
  logic [rmsd_pkg::DEN_W:0]      div_sh;
  logic                          div_ge;
  logic [rmsd_pkg::SREM_W+1:0]   sq_cur, sq_trial;
  logic                          sq_ge;

  assign div_sh   = {rem_r, 1'b0};
  assign div_ge   = (div_sh >= {1'b0, den_r});
  assign sq_cur   = {srem_r, q_r[rmsd_pkg::Q_W-1 -: 2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);

  always_ff @(posedge clk) begin
    unique if (cmd.check) begin
      sat_r  <= sat_now;
      mism_r <= mism;
      rem_r  <= rmsd_pkg::DEN_W'(sum_r);
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? rmsd_pkg::DEN_W'(div_sh - {1'b0, den_r})
                      : rmsd_pkg::DEN_W'(div_sh);
      q_r   <= {q_r[rmsd_pkg::Q_W-2:0], div_ge};
    end else if (cmd.sqrt_step) begin
      srem_r <= sq_ge ? rmsd_pkg::SREM_W'(sq_cur - sq_trial)
                      : rmsd_pkg::SREM_W'(sq_cur);
      root_r <= {root_r[rmsd_pkg::ROOT_W-2:0], sq_ge};
      q_r    <= {q_r[rmsd_pkg::Q_W-3:0], 2'b00};
    end else begin
    end
  end

  // Output register
  logic                        out_valid_r;
  logic [rmsd_pkg::RMS_W-1:0]  out_rms_r;
  logic                        out_mism_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_rms_r  <= sat_r ? rmsd_pkg::ONE_Q16 : {1'b0, root_r};
      out_mism_r <= mism_r;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {6'd0, out_mism_r, out_rms_r};
  assign status.sat      = sat_now;
  assign status.out_free = !out_valid_r || out_tready;

  `RMSD_ASSERT_NEXT(a_sum_cleared, cmd.check, sum_r == '0, "sum not cleared after result")
  `RMSD_ASSERT(a_root_rem_bound, cmd.sqrt_step |-> (srem_r <= {1'b0, root_r, 1'b0}), "root remainder out of range")
  `RMSD_ASSERT(a_rms_bound, out_valid_r |-> (out_rms_r <= rmsd_pkg::ONE_Q16), "result above 1.0")

endmodule

`default_nettype wire

// ===== sv/rgb_image_rms_difference_core.sv =====
// RGB image RMS difference core: accumulates squared channel differences of
// pixel pairs and reports the normalised RMS difference on the last beat.
// Instantiates rmsd_ctrl and rmsd_dp; depends on rmsd_pkg.
//
// Usage:
//   Write the four image sizes through cfg_wr_en/cfg_addr/cfg_wr_data while
//   idle (index 0 first width, 1 first height, 2 second width, 3 second
//   height). Then stream the overlap region row by row on the in_ channel,
//   one pixel pair a beat, with in_tlast on the final pair.
//   Ordinary beats are taken one per cycle. After the last beat in_tready
//   drops for the final sequence: the set-up states FLUSH, SCALE and CHECK,
//   restoring division (one quotient bit a cycle) and square root (one root
//   bit a cycle), then the output register is loaded and out_tvalid rises;
//   a size mismatch, an empty overlap or a saturated sum skip both the
//   division and the square root.
//   The result waits in the output register while new beats are taken; if a
//   further last beat finishes before it is taken, the core holds until
//   out_tready frees the register.
//   Reset (rst_n low, synchronous) clears the sum, sets all sizes to 1 and
//   empties the output register.
`default_nettype none

module rgb_image_rms_difference_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [rmsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire  [rmsd_pkg::DIM_W-1:0]         cfg_wr_data,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // first_red, first_green, first_blue, second_red, second_green, second_blue
  input  wire  [rmsd_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire                                in_tlast,   // last_pixel
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // rms_difference [16:0], dims_mismatch [17], zero fill [23:18]
  output logic [rmsd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  rmsd_pkg::cmd_t    cmd;
  rmsd_pkg::status_t status;

  rmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rmsd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

`default_nettype wire

// ===== tb/tb_rgb_image_rms_difference_core.sv =====
// Self-checking testbench of rgb_image_rms_difference_core: streams pixel-pair frames
// under several image sizes, predicts each RMS result and compares it beat by beat.
// Depends on rmsd_pkg and the core only.
module tb_rgb_image_rms_difference_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W       = rmsd_pkg::CH_W;
  localparam int DIM_W      = rmsd_pkg::DIM_W;
  localparam int SUM_W      = rmsd_pkg::SUM_W;
  localparam int DEN_W      = rmsd_pkg::DEN_W;
  localparam int RMS_W      = rmsd_pkg::RMS_W;
  localparam int CFG_ADDR_W = rmsd_pkg::CFG_ADDR_W;
  localparam int IN_DATA_W  = rmsd_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = rmsd_pkg::OUT_DATA_W;

  localparam int unsigned OV_LIMIT_W    = 4096;
  localparam int unsigned OV_LIMIT_H    = 4096;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned TOTAL_PAIRS   = 1800;
  localparam logic [SUM_W:0] SUM_SAT    = {1'b0, {SUM_W{1'b1}}};

  typedef enum logic [1:0] {PX_RANDOM, PX_EQUAL, PX_EXTREME, PX_NEAR} pixel_style_t;

  typedef struct packed {
    logic [2:0][CH_W-1:0] second_rgb;  // red in the lowest byte
    logic [2:0][CH_W-1:0] first_rgb;
    logic                 last;
  } pixel_pair_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms;
    logic             mismatch;
  } rms_result_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
  logic [DIM_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tlast    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Model state: sizes as written and the running squared error sum
  logic [DIM_W-1:0] size_fw = DIM_W'(1), size_fh = DIM_W'(1);
  logic [DIM_W-1:0] size_sw = DIM_W'(1), size_sh = DIM_W'(1);
  logic [SUM_W-1:0] sq_err_sum = '0;

  pixel_pair_t pend_pairs[$];
  rms_result_t rms_expected[$];
  pixel_pair_t cur_pair;
  int unsigned pairs_queued = 0;
  int unsigned err_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic [15:0] cyc = '0;
  wire         quiet = cyc[9] & cyc[8];

  rgb_image_rms_difference_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // first r, g, b, then second r, g, b
    .in_tlast   (in_tlast),   // last_pixel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // rms_difference, dims_mismatch, zero fill
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_rgb_image_rms_difference_core: FAIL");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1'b1;

  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [DIM_W-1:0] dim_gap(logic [DIM_W-1:0] a,
                                               logic [DIM_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Largest r in [0, 1.0] with (r/2^16)^2 * area3 * 255^2 <= sum, exact integers
  function automatic logic [RMS_W-1:0] rms_of_sum(logic [SUM_W-1:0] sum,
                                                  logic [DEN_W-1:0] area3);
    int unsigned lo, hi, mid;
    logic [127:0] lhs, rhs;
    lo = 0;
    hi = 65536;
    if (area3 == '0) return rmsd_pkg::ONE_Q16;
    rhs = 128'(sum) << 32;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 128'(mid) * 128'(mid) * 128'(65025) * 128'(area3);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return RMS_W'(lo);
  endfunction

  task automatic accumulate_pair(pixel_pair_t p);
    logic [SUM_W:0] add, total;
    logic [CH_W-1:0] d;
    logic [DIM_W-1:0] ov_w, ov_h;
    rms_result_t res;
    add = '0;
    for (int c = 0; c < 3; c++) begin
      d = (p.first_rgb[c] > p.second_rgb[c]) ? p.first_rgb[c] - p.second_rgb[c]
                                             : p.second_rgb[c] - p.first_rgb[c];
      add += (SUM_W+1)'(d) * (SUM_W+1)'(d);
    end
    total = {1'b0, sq_err_sum} + add;
    sq_err_sum = (total > SUM_SAT) ? SUM_SAT[SUM_W-1:0] : total[SUM_W-1:0];
    if (p.last) begin
      res.mismatch = (dim_gap(size_fw, size_sw) > 1) || (dim_gap(size_fh, size_sh) > 1);
      ov_w = (size_fw < size_sw) ? size_fw : size_sw;
      ov_h = (size_fh < size_sh) ? size_fh : size_sh;
      if (ov_w > OV_LIMIT_W) ov_w = DIM_W'(OV_LIMIT_W);
      if (ov_h > OV_LIMIT_H) ov_h = DIM_W'(OV_LIMIT_H);
      res.rms = res.mismatch ? rmsd_pkg::ONE_Q16
                             : rms_of_sum(sq_err_sum,
                                          DEN_W'(ov_w) * DEN_W'(ov_h) * DEN_W'(3));
      rms_expected.push_back(res);
      sq_err_sum = '0;
    end
  endtask

  task automatic report_error(string what, rms_result_t want, logic [OUT_DATA_W-1:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s: expected rms %0d mismatch %0b, got rms %0d mismatch %0b",
               $realtime, what, want.rms, want.mismatch, got[RMS_W-1:0], got[RMS_W]);
  endtask

  // Sender: hold the beat until taken, then idle for a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) accumulate_pair(cur_pair);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pend_pairs.size() != 0) begin
          cur_pair = pend_pairs.pop_front();
          in_tdata <= {cur_pair.second_rgb, cur_pair.first_rgb};
          in_tlast <= cur_pair.last;
          in_tvalid <= 1'b1;
          gap_left = idle_len(quiet);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest expectation
  always @(posedge clk) begin
    rms_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (rms_expected.size() == 0) begin
          want = 'x;
          report_error("result with nothing expected", want, out_tdata);
        end else begin
          want = rms_expected.pop_front();
          if (out_tdata[RMS_W-1:0] !== want.rms || out_tdata[RMS_W] !== want.mismatch)
            report_error("result mismatch", want, out_tdata);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = idle_len(quiet);
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pend_pairs.size() != 0 || in_tvalid || rms_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(int unsigned fw, int unsigned fh, int unsigned sw, int unsigned sh);
    logic [CFG_ADDR_W-1:0] idx[4];
    logic [DIM_W-1:0] val[4];
    idx = '{rmsd_pkg::REG_FIRST_WIDTH, rmsd_pkg::REG_FIRST_HEIGHT,
            rmsd_pkg::REG_SECOND_WIDTH, rmsd_pkg::REG_SECOND_HEIGHT};
    val = '{DIM_W'(fw), DIM_W'(fh), DIM_W'(sw), DIM_W'(sh)};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_addr <= idx[i];
      cfg_wr_data <= val[i];
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    size_fw = val[0];
    size_fh = val[1];
    size_sw = val[2];
    size_sh = val[3];
  endtask

  task automatic push_explicit(logic [23:0] first, logic [23:0] second, bit last);
    pixel_pair_t p;
    p.first_rgb = first;
    p.second_rgb = second;
    p.last = last;
    pend_pairs.push_back(p);
    pairs_queued++;
  endtask

  function automatic logic [CH_W-1:0] rand_chan();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Queue n pairs of one style; the final one carries the last flag if asked
  task automatic push_frame(int unsigned n, pixel_style_t style, bit with_last);
    logic [2:0][CH_W-1:0] a, b;
    for (int unsigned k = 0; k < n; k++) begin
      for (int c = 0; c < 3; c++) begin
        a[c] = rand_chan();
        case (style)
          PX_EQUAL:   b[c] = a[c];
          PX_EXTREME: begin
            a[c] = $urandom_range(0, 1) ? '1 : '0;
            b[c] = ~a[c];
          end
          PX_NEAR:    b[c] = a[c] + CH_W'($urandom_range(0, 6)) - CH_W'(3);
          default:    b[c] = rand_chan();
        endcase
      end
      push_explicit(a, b, with_last && (k == n - 1));
    end
  endtask

  initial begin
    int unsigned r, fw, fh, sw, sh, ov_w, ov_h, n, frames;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sizes after reset are 1 by 1: zero, full-scale and single-channel error
    push_explicit(24'h000000, 24'h000000, 1'b1);
    push_explicit(24'hFFFFFF, 24'h000000, 1'b1);
    push_explicit(24'h000000, 24'hFFFFFF, 1'b1);
    push_explicit(24'h0000FF, 24'h000000, 1'b1);
    write_sizes(2, 2, 2, 2);
    push_frame(4, PX_RANDOM, 1'b1);
    // more pairs than the area holds: saturate at 1.0
    write_sizes(1, 1, 1, 1);
    push_frame(3, PX_EXTREME, 1'b1);
    write_sizes(5, 1, 2, 1);
    push_frame(2, PX_RANDOM, 1'b1);
    write_sizes(2, 1, 2, 4);
    push_frame(1, PX_RANDOM, 1'b1);
    // empty overlap
    write_sizes(0, 1, 1, 1);
    push_frame(1, PX_RANDOM, 1'b1);
    // widths beyond the overlap limit get clamped
    write_sizes(8191, 1, 8191, 2);
    push_frame(3, PX_NEAR, 1'b1);
    write_sizes(4096, 4096, 4096, 4096);
    push_frame(2, PX_EXTREME, 1'b1);

    while (pairs_queued < TOTAL_PAIRS) begin
      r = $urandom_range(0, 99);
      fw = $urandom_range(1, 8);
      fh = $urandom_range(1, 8);
      sw = fw + $urandom_range(0, 2) - 1;
      sh = fh + $urandom_range(0, 2) - 1;
      if (r >= 70 && r < 80) begin
        if ($urandom_range(0, 1)) sw = fw + $urandom_range(2, 6);
        else sh = fh + $urandom_range(2, 6);
      end else if (r >= 80 && r < 85) begin
        fw = 0;
        sw = $urandom_range(0, 1);
      end else if (r >= 85 && r < 93) begin
        fw = $urandom_range(4000, 8191);
        sw = fw - $urandom_range(0, 1);
      end else if (r >= 93) begin
        fw = $urandom_range(9, 40);
        sw = fw;
        fh = $urandom_range(1, 2);
        sh = fh;
      end
      if ($urandom_range(0, 1)) write_sizes(fw, fh, sw, sh);
      else write_sizes(sw, sh, fw, fh);

      ov_w = (fw < sw) ? fw : sw;
      ov_h = (fh < sh) ? fh : sh;
      if (ov_w > OV_LIMIT_W) ov_w = OV_LIMIT_W;
      if (ov_h > OV_LIMIT_H) ov_h = OV_LIMIT_H;
      frames = $urandom_range(1, 4);
      for (int unsigned f = 0; f < frames; f++) begin
        n = ov_w * ov_h;
        if (n == 0 || n > 96) n = $urandom_range(1, 40);
        r = $urandom_range(0, 99);
        // broken frames: wrong length, or a stray run of pairs in front
        if (r < 8) n = $urandom_range(1, n + 3);
        else if (r < 13) push_frame($urandom_range(1, 5), PX_RANDOM, 1'b0);
        push_frame(n, pixel_style_t'($urandom_range(0, 3)), 1'b1);
      end
      // leave some error in the sum to carry over into the next sizes
      if ($urandom_range(0, 99) < 5) push_frame($urandom_range(1, 4), PX_RANDOM, 1'b0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("tb_rgb_image_rms_difference_core: PASS");
    end else begin
      $display("tb_rgb_image_rms_difference_core: FAIL");
    end
    $finish;
  end

endmodule
